// ===== rtl/miller_rabin_witness_test_macros.svh =====
// Assertion macros shared by the verification checkers of the witness test.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MILLER_RABIN_WITNESS_TEST_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_MACROS_SVH

// Implication into the next cycle, checked only outside reset.
`define MRWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrwt assertion failed");

// Implication into the next cycle, checked during reset as well.
`define MRWT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mrwt assertion failed");

`endif

// ===== rtl/mrwt_pkg.sv =====
// Package for the Miller-Rabin witness test: sequencer states and the
// status struct of the modular multiplier. No dependencies.
package mrwt_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TZ   = 8'b0000_0010,
    S_RED  = 8'b0000_0100,
    S_SQ   = 8'b0000_1000,
    S_ML   = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_LOOP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } mrwt_state_t;

  // Status reported by the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ===== rtl/mrwt_if.sv =====
// Valid/ready channel interfaces for the witness test: the candidate and base
// input channel and the one-bit result channel. No dependencies.
interface mrwt_in_if #(parameter int NUM_BITS = 31);
  logic                valid;
  logic                ready;
  logic [NUM_BITS-1:0] candidate;
  logic [NUM_BITS-1:0] witness_base;

  modport source (output valid, output candidate, output witness_base, input ready);
  modport sink   (input valid, input candidate, input witness_base, output ready);
endinterface

interface mrwt_out_if;
  logic valid;
  logic ready;
  logic probably_prime;

  modport source (output valid, output probably_prime, input ready);
  modport sink   (input valid, input probably_prime, output ready);
endinterface

// ===== rtl/mrwt_modmul.sv =====
// Shared bit-serial modular multiplier: x*y mod n, one bit of y per cycle.
// Depends on mrwt_pkg for the status struct.
module mrwt_modmul import mrwt_pkg::*; #(
  parameter int NUM_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] x_in,
  input  logic [NUM_BITS-1:0] y_in,
  input  logic [NUM_BITS-1:0] n_in,
  output logic [NUM_BITS-1:0] result,
  output mm_stat_t            stat
);

  localparam int CW = $clog2(NUM_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] x_r, x_nxt;
  logic [NUM_BITS-1:0] y_r, y_nxt;
  logic [NUM_BITS-1:0] n_r, n_nxt;

  logic [NUM_BITS:0]   dbl, dbl_red, sum, sum_red;
  logic [NUM_BITS-1:0] addend;

  // One Horner step: double the accumulator, then add x when the bit of y is set,
  // each followed by a single conditional subtraction of n.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, n_r}) ? (dbl - {1'b0, n_r}) : dbl;
    addend  = y_r[NUM_BITS-1] ? x_r : '0;
    sum     = {1'b0, dbl_red[NUM_BITS-1:0]} + {1'b0, addend};
    sum_red = (sum >= {1'b0, n_r}) ? (sum - {1'b0, n_r}) : sum;
  end

  // Operand load and step sequencing.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    n_nxt    = n_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_BITS - 1);
      acc_nxt  = '0;
      x_nxt    = x_in;
      y_nxt    = y_in;
      n_nxt    = n_in;
    end else if (busy_r) begin
      acc_nxt = sum_red[NUM_BITS-1:0];
      y_nxt   = {y_r[NUM_BITS-2:0], 1'b0};
      if (cnt_r == CW'(0)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    n_r   <= n_nxt;
  end

  assign result    = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/miller_rabin_witness_test.sv =====
// Top level of the Miller-Rabin witness round: sequencer around one shared
// modular multiplier. Depends on mrwt_pkg, mrwt_if.sv and mrwt_modmul.
//
//   Port     | Direction | Carries
//   ---------+-----------+--------------------------------------------
//   in_ch    | sink      | candidate n, witness_base a
//   out_ch   | source    | probably_prime
//
// Every modular product runs on the shared multiplier.
// A transaction needs one base reduction, NUM_BITS squarings, one product per
// set bit of d and up to s - 1 further squarings, once the factors of two
// are stripped from n-1. Candidates below two skip these steps: the sequencer
// goes to S_DONE and then loads a not-prime result into the output register.
// Synchronous reset clears the sequencer and the result valid; a stalled
// result holds while the next transaction is accepted and worked on.
module miller_rabin_witness_test import mrwt_pkg::*; #(
  parameter int NUM_BITS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  mrwt_in_if.sink   in_ch,
  mrwt_out_if.source out_ch
);

  localparam int CW = $clog2(NUM_BITS);

  mrwt_state_t         state_r, state_nxt;
  logic [NUM_BITS-1:0] n_r, n_nxt;
  logic [NUM_BITS-1:0] m_r, m_nxt;
  logic [NUM_BITS-1:0] base_r, base_nxt;
  logic [NUM_BITS-1:0] d_r, d_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [CW-1:0]       s_r, s_nxt;
  logic [CW-1:0]       bcnt_r, bcnt_nxt;
  logic [CW-1:0]       jrem_r, jrem_nxt;
  logic                go_r, go_nxt;
  logic                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_prob_r, out_prob_nxt;

  logic                mm_start;
  logic [NUM_BITS-1:0] mm_x, mm_y, mm_res;
  mm_stat_t            mm_stat;

  // Operand selection for the shared multiplier.
  always_comb begin
    mm_x = acc_r;
    mm_y = acc_r;
    if (state_r == S_RED) begin
      mm_x = NUM_BITS'(1);
      mm_y = base_r;
    end else if (state_r == S_ML) begin
      mm_y = base_r;
    end
  end

  assign mm_start = go_r && !mm_stat.busy;

  mrwt_modmul #(.NUM_BITS(NUM_BITS)) u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x_in   (mm_x),
    .y_in   (mm_y),
    .n_in   (n_r),
    .result (mm_res),
    .stat   (mm_stat)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    base_nxt      = base_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    bcnt_nxt      = bcnt_r;
    jrem_nxt      = jrem_r;
    go_nxt        = go_r && !mm_start;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_prob_nxt  = out_prob_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt    = in_ch.candidate;
          m_nxt    = in_ch.candidate - NUM_BITS'(1);
          d_nxt    = in_ch.candidate - NUM_BITS'(1);
          base_nxt = in_ch.witness_base;
          s_nxt    = '0;
          if (in_ch.candidate < NUM_BITS'(2)) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TZ;
          end
        end
      end
      // Strip factors of two from n-1, one per cycle.
      S_TZ: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + CW'(1);
        end else begin
          state_nxt = S_RED;
          go_nxt    = 1'b1;
        end
      end
      // Reduce the base: 1 * a mod n.
      S_RED: begin
        if (mm_stat.done) begin
          base_nxt  = mm_res;
          acc_nxt   = NUM_BITS'(1);
          bcnt_nxt  = CW'(NUM_BITS - 1);
          state_nxt = S_SQ;
          go_nxt    = 1'b1;
        end
      end
      // Square step of the exponentiation.
      S_SQ: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          if (d_r[bcnt_r]) begin
            state_nxt = S_ML;
            go_nxt    = 1'b1;
          end else if (bcnt_r == CW'(0)) begin
            state_nxt = S_CHK;
          end else begin
            bcnt_nxt = bcnt_r - CW'(1);
            go_nxt   = 1'b1;
          end
        end
      end
      // Multiply step of the exponentiation.
      S_ML: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          if (bcnt_r == CW'(0)) begin
            state_nxt = S_CHK;
          end else begin
            bcnt_nxt  = bcnt_r - CW'(1);
            state_nxt = S_SQ;
            go_nxt    = 1'b1;
          end
        end
      end
      // Check a^d against 1 and n-1.
      S_CHK: begin
        if (acc_r == NUM_BITS'(1) || acc_r == m_r) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (s_r <= CW'(1)) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          jrem_nxt  = s_r - CW'(1);
          state_nxt = S_LOOP;
          go_nxt    = 1'b1;
        end
      end
      // Repeated squaring looking for n-1.
      S_LOOP: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          if (mm_res == m_r) begin
            res_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (mm_res == NUM_BITS'(1) || jrem_r == CW'(1)) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            jrem_nxt = jrem_r - CW'(1);
            go_nxt   = 1'b1;
          end
        end
      end
      // Hand the answer to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_prob_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    base_r     <= base_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    s_r        <= s_nxt;
    bcnt_r     <= bcnt_nxt;
    jrem_r     <= jrem_nxt;
    res_r      <= res_nxt;
    out_prob_r <= out_prob_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.probably_prime = out_prob_r;

endmodule

// ===== rtl/mrwt_checker.sv =====
// Port-level checker for the witness test and its bind to the top level.
// Depends on miller_rabin_witness_test_macros.svh.
`include "miller_rabin_witness_test_macros.svh"

module mrwt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_prob
);

  // Reset empties the result register.
  `MRWT_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

  // The block works on one transaction at a time.
  `MRWT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A stalled result stays offered.
  `MRWT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its value.
  `MRWT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_prob))

endmodule

bind miller_rabin_witness_test mrwt_checker u_mrwt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_prob  (out_ch.probably_prime)
);
